@@ rtl/arr_list_pkg.sv @@
package arr_list_pkg;

    // payload field widths on the stream ports
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;
    localparam int ELEM_W   = 32;
    localparam int IDX_W    = 6;

    localparam int S_DATA_W = 40;   // position, value, zero fill
    localparam int M_DATA_W = 48;   // status, count, element, element_index

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_START = 3'd0,
        FN_INS_END   = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_START = 3'd3,
        FN_DEL_END   = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_DEL_VALUE = 3'd6,
        FN_READ_ALL  = 3'd7
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_EMPTY      = 3'd2,
        STAT_BAD_POS    = 3'd3,
        STAT_NOT_FOUND  = 3'd4,
        STAT_EMPTY_READ = 3'd5
    } status_t;

endpackage

@@ rtl/array_list_insert_delete.sv @@
// Packed list of up to DEPTH signed values held in one synchronous memory (one write port,
// one registered read port) plus an element count. One operation is taken per input
// transaction, selected by s_axis_tuser; the block takes a new transaction only when the
// previous one has finished its memory work, while its result may still wait in the output
// register. Insert or delete at the tail touches at most one slot; otherwise the entries
// behind the target slot move one per cycle through the read-then-write pipe, the
// insert walking down from the tail and the delete walking up past the gap.
// Delete by value scans one entry per cycle until the match, then moves the entries behind
// it the same way. A readout gives one element per cycle while m_axis_tready stays high.
// Every change answers with one transaction carrying status and the new count.
// The memory needs no clearing after reset: only entries below the count are ever read.
module array_list_insert_delete
    import arr_list_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,   // position[6:0], value[38:7], zero[39]
    input  logic [FUNC_W-1:0]   s_axis_tuser,   // func[2:0]

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [M_DATA_W-1:0] m_axis_tdata,   // status[2:0], count[9:3], element[41:10],
                                                // element_index[47:42]
    output logic                m_axis_tlast    // last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_DN,
        S_SEARCH,
        S_READ,
        S_RESP
    } state_t;

    state_t                        state_reg, state_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]                 end_reg, end_next;
    logic                          pend_reg, pend_next;
    logic                          more_reg, more_next;
    logic signed [DATA_WIDTH-1:0]  val_reg, val_next;
    status_t                       status_reg, status_next;

    logic                          out_valid_reg, out_valid_next;
    status_t                       out_status_reg, out_status_next;
    logic [COUNT_W-1:0]            out_count_reg, out_count_next;
    logic [ELEM_W-1:0]             out_elem_reg, out_elem_next;
    logic [IDX_W-1:0]              out_idx_reg, out_idx_next;
    logic                          out_last_reg, out_last_next;

    logic signed [DATA_WIDTH-1:0]  mem [DEPTH];
    logic signed [DATA_WIDTH-1:0]  rd_data_reg;
    logic                          rd_en;
    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic signed [DATA_WIDTH-1:0]  wr_data;

    func_t                         in_func;
    logic [POS_W-1:0]              in_pos;
    logic signed [VALUE_W-1:0]     in_value;
    logic signed [63:0]            in_wide;
    logic signed [DATA_WIDTH-1:0]  in_val;
    logic signed [63:0]            rd_wide;
    logic [XW-1:0]                 pos_x;
    logic [XW-1:0]                 n_x;
    logic [XW-1:0]                 at_x;
    logic [AW-1:0]                 at_a;
    logic [CW-1:0]                 count_m1;
    logic [AW-1:0]                 nm1;
    logic                          in_fire;
    logic                          out_free;
    logic                          out_load;
    logic                          rd_load;
    logic                          rd_issue;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign in_func  = func_t'(s_axis_tuser);
    assign in_pos   = s_axis_tdata[POS_W-1:0];
    assign in_value = s_axis_tdata[POS_W+VALUE_W-1:POS_W];
    assign in_wide  = 64'(in_value);
    assign in_val   = in_wide[DATA_WIDTH-1:0];
    assign rd_wide  = 64'(rd_data_reg);

    assign pos_x    = XW'(in_pos);
    assign n_x      = XW'(count_reg);
    assign count_m1 = count_reg - CW'(1);
    assign nm1      = count_m1[AW-1:0];
    assign at_a     = at_x[AW-1:0];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign rd_load  = (state_reg == S_READ) && pend_reg && out_free;
    assign rd_issue = more_reg && (!pend_reg || rd_load);

    // zero-based target slot of an insert or delete
    always_comb
    begin
        case (in_func)
            FN_INS_START: at_x = '0;
            FN_INS_END:   at_x = n_x;
            FN_INS_POS:   at_x = pos_x - XW'(1);
            FN_DEL_START: at_x = '0;
            FN_DEL_END:   at_x = n_x - XW'(1);
            FN_DEL_POS:   at_x = pos_x - XW'(1);
            default:      at_x = '0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        end_next        = end_reg;
        pend_next       = pend_reg;
        more_next       = more_reg;
        val_next        = val_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_elem_next   = out_elem_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = val_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    val_next    = in_val;
                    status_next = STAT_OK;
                    state_next  = S_RESP;
                    if (in_func inside {FN_INS_START, FN_INS_END, FN_INS_POS})
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (in_func == FN_INS_POS &&
                                 (pos_x == '0 || pos_x > n_x + XW'(1)))
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            if (at_x == n_x)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = at_a;
                                wr_data = in_val;
                            end
                            else
                            begin
                                ptr_next   = nm1;
                                end_next   = at_a;
                                more_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_UP;
                            end
                        end
                    end
                    else if (in_func inside {FN_DEL_START, FN_DEL_END, FN_DEL_POS,
                                             FN_DEL_VALUE})
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (in_func == FN_DEL_VALUE)
                        begin
                            ptr_next   = '0;
                            end_next   = nm1;
                            more_next  = 1'b1;
                            pend_next  = 1'b0;
                            state_next = S_SEARCH;
                        end
                        else if (in_func == FN_DEL_POS && (pos_x == '0 || pos_x > n_x))
                        begin
                            status_next = STAT_BAD_POS;
                        end
                        else
                        begin
                            count_next = count_m1;
                            if (at_x != n_x - XW'(1))
                            begin
                                ptr_next   = at_a + AW'(1);
                                end_next   = nm1;
                                more_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_DN;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_EMPTY_READ;
                        end
                        else
                        begin
                            ptr_next   = '0;
                            end_next   = nm1;
                            more_next  = 1'b1;
                            pend_next  = 1'b0;
                            state_next = S_READ;
                        end
                    end
                end
            end

            // walk down from the tail: read slot i, write it to i+1 next cycle
            S_UP:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wr_ptr_reg + AW'(1);
                    wr_data = rd_data_reg;
                end
                else if (!more_reg)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = end_reg;
                    wr_data    = val_reg;
                    state_next = S_RESP;
                end
                if (more_reg)
                begin
                    rd_en       = 1'b1;
                    wr_ptr_next = ptr_reg;
                    if (ptr_reg == end_reg)
                        more_next = 1'b0;
                    else
                        ptr_next = ptr_reg - AW'(1);
                end
                pend_next = more_reg;
            end

            // walk up past the gap: read slot i, write it to i-1 next cycle
            S_DN:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = wr_ptr_reg - AW'(1);
                    wr_data = rd_data_reg;
                end
                if (more_reg)
                begin
                    rd_en       = 1'b1;
                    wr_ptr_next = ptr_reg;
                    if (ptr_reg == end_reg)
                        more_next = 1'b0;
                    else
                        ptr_next = ptr_reg + AW'(1);
                end
                pend_next = more_reg;
                if (!pend_reg && !more_reg)
                    state_next = S_RESP;
            end

            S_SEARCH:
            begin
                if (pend_reg && rd_data_reg == val_reg)
                begin
                    count_next = count_m1;
                    if (wr_ptr_reg == end_reg)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        ptr_next   = wr_ptr_reg + AW'(1);
                        more_next  = 1'b1;
                        pend_next  = 1'b0;
                        state_next = S_DN;
                    end
                end
                else
                begin
                    if (more_reg)
                    begin
                        rd_en       = 1'b1;
                        wr_ptr_next = ptr_reg;
                        if (ptr_reg == end_reg)
                            more_next = 1'b0;
                        else
                            ptr_next = ptr_reg + AW'(1);
                    end
                    pend_next = more_reg;
                    if (!pend_reg && !more_reg)
                    begin
                        status_next = STAT_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                end
            end

            // read data register holds while the output is stalled
            S_READ:
            begin
                if (rd_load)
                begin
                    out_load        = 1'b1;
                    out_status_next = STAT_OK;
                    out_count_next  = COUNT_W'(count_reg);
                    out_elem_next   = rd_wide[ELEM_W-1:0];
                    out_idx_next    = IDX_W'(wr_ptr_reg);
                    out_last_next   = (wr_ptr_reg == end_reg);
                    if (wr_ptr_reg == end_reg)
                        state_next = S_IDLE;
                end
                if (rd_issue)
                begin
                    rd_en       = 1'b1;
                    wr_ptr_next = ptr_reg;
                    if (ptr_reg == end_reg)
                        more_next = 1'b0;
                    else
                        ptr_next = ptr_reg + AW'(1);
                    pend_next = 1'b1;
                end
                else if (rd_load)
                begin
                    pend_next = 1'b0;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = COUNT_W'(count_reg);
                    out_elem_next   = '0;
                    out_idx_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            wr_ptr_reg     <= '0;
            end_reg        <= '0;
            pend_reg       <= 1'b0;
            more_reg       <= 1'b0;
            val_reg        <= '0;
            status_reg     <= STAT_OK;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_count_reg  <= '0;
            out_elem_reg   <= '0;
            out_idx_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            end_reg        <= end_next;
            pend_reg       <= pend_next;
            more_reg       <= more_next;
            val_reg        <= val_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_elem_reg   <= out_elem_next;
            out_idx_reg    <= out_idx_next;
            out_last_reg   <= out_last_next;
        end
    end

    // list storage: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[ptr_reg];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_idx_reg, out_elem_reg, out_count_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

    // the shift pipes never read and write one slot in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en && wr_addr == ptr_reg))
        else $error("read and write collide on one list slot");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above depth");

    // the count moves only as the result of an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != count_next) |-> (state_reg == S_IDLE && in_fire) ||
                                      state_reg == S_SEARCH)
        else $error("element count changed outside an operation");

endmodule
